FILE: hdl/lpht_pkg.sv
// Shared types, constants and codes for the linear probing hash table.
package lpht_pkg;

   localparam int TABLE_SIZE   = 64;   // must be a power of two
   localparam int KEY_BYTES    = 8;
   localparam int ADDR_W       = $clog2(TABLE_SIZE);
   localparam int CNT_W        = ADDR_W + 1;
   localparam int KEY_W        = 64;
   localparam int KLEN_W       = 4;
   localparam int VALUE_W      = 32;
   localparam int LIMIT_W      = 7;
   localparam int USED_W       = CNT_W;

   localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME  = 32'd16777619;
   localparam logic [6:0]  ENTRY_LIMIT_RESET = 7'd38;

   typedef enum logic [1:0] {
      KIND_EMPTY = 2'd0,
      KIND_TOMB  = 2'd1,
      KIND_USED  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      FUNC_LOOKUP  = 2'd0,
      FUNC_INSERT  = 2'd1,
      FUNC_DELETE  = 2'd2,
      FUNC_REVERSE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HASH,
      S_ISSUE,
      S_CHECK,
      S_DECIDE,
      S_OUT
   } state_type;

   typedef struct packed {
      kind_type            kind;
      logic [KLEN_W-1:0]   key_length;
      logic [KEY_W-1:0]    key;
      logic [VALUE_W-1:0]  value;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

endpackage

FILE: hdl/lpht_ram.sv
// Generic single write port, single read port RAM with registered read data.
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: hdl/linear_probe_hash_table.sv
// Top level of the open addressing key/value table with linear probing.
//
// A request beat carries a function code, a key of up to eight bytes with its
// length, and a 32-bit value; every request produces exactly one response
// beat. The home slot is the FNV-1a hash of the key modulo the table size,
// and probing walks forward one slot at a time, passing tombstones, until an
// empty slot, a matching key, or a full lap. Lookup, insert or overwrite,
// delete (leaving a tombstone) and reverse lookup by value are supported.
// The block works on one request at a time. A keyed request is first
// hashed one byte per cycle through a constant multiply, then each probed
// slot is a read of the slot RAM (S_ISSUE) followed by a compare (S_CHECK),
// then the table is updated (S_DECIDE) and the result handed off (S_OUT).
// A reverse lookup scans slots in order from zero. The response sits in
// its own output register, so a new request is taken as soon as the
// engine is free even while the previous response is stalled. Slot
// contents live in a RAM; a flip-flop valid bit per slot, cleared by
// reset, makes every slot read as empty after reset, so no clearing
// pass is needed. The entry limit register may only be written while
// no request is in flight.
module linear_probe_hash_table
   import lpht_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // Request channel.
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_func,
   input  logic [KEY_W-1:0]    req_key_bytes,
   input  logic [KLEN_W-1:0]   req_key_length,
   input  logic [VALUE_W-1:0]  req_data_value,
   // Response channel.
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_found,
   output logic [1:0]          rsp_status,
   output logic [VALUE_W-1:0]  rsp_value_out,
   output logic [KEY_W-1:0]    rsp_key_out,
   output logic [KLEN_W-1:0]   rsp_key_out_length,
   // Configuration.
   input  logic                csr_write_enable,
   input  logic [LIMIT_W-1:0]  csr_write_data
);

   // Control state.
   state_type state_ff, state_in;
   logic [TABLE_SIZE-1:0] valid_ff, valid_in;
   logic [USED_W-1:0]     used_ff, used_in;
   logic [LIMIT_W-1:0]    limit_ff;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Request held for the life of one operation.
   func_type              func_ff, func_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [KLEN_W-1:0]     len_ff, len_in;
   logic [VALUE_W-1:0]    data_ff, data_in;

   // Hash and probe walk.
   logic [31:0]           hash_ff, hash_in;
   logic [KLEN_W-1:0]     byte_cnt_ff, byte_cnt_in;
   logic [ADDR_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]      probe_cnt_ff, probe_cnt_in;
   logic                  hit_ff, hit_in;
   logic                  have_empty_ff, have_empty_in;
   logic                  have_tomb_ff, have_tomb_in;
   logic [ADDR_W-1:0]     hit_idx_ff, hit_idx_in;
   logic [ADDR_W-1:0]     empty_idx_ff, empty_idx_in;
   logic [ADDR_W-1:0]     tomb_idx_ff, tomb_idx_in;
   logic [VALUE_W-1:0]    hit_value_ff, hit_value_in;
   logic [KEY_W-1:0]      hit_key_ff, hit_key_in;
   logic [KLEN_W-1:0]     hit_len_ff, hit_len_in;

   // Pending result, handed to the output register in S_OUT.
   logic                  res_found_ff, res_found_in;
   status_type            res_status_ff, res_status_in;
   logic [VALUE_W-1:0]    res_value_ff, res_value_in;
   logic [KEY_W-1:0]      res_key_ff, res_key_in;
   logic [KLEN_W-1:0]     res_len_ff, res_len_in;

   // Output register.
   logic                  out_found_ff, out_found_in;
   logic [1:0]            out_status_ff, out_status_in;
   logic [VALUE_W-1:0]    out_value_ff, out_value_in;
   logic [KEY_W-1:0]      out_key_ff, out_key_in;
   logic [KLEN_W-1:0]     out_len_ff, out_len_in;

   // Slot RAM ports.
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   slot_type              wr_slot;
   slot_type              rd_slot;
   logic [SLOT_W-1:0]     rd_word;

   // Helpers.
   logic                  req_beat;
   logic                  out_free;
   logic [KLEN_W-1:0]     req_len_clamped;
   logic [KEY_W-1:0]      req_key_masked;
   logic [7:0]            hash_byte;
   kind_type              probe_kind;
   logic                  key_match;
   logic                  value_match;
   logic                  last_probe;
   logic                  room_for_new;

   assign req_beat = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Long keys are cut to KEY_BYTES, and bytes beyond the length are zero.
   always_comb begin
      req_len_clamped = (req_key_length > KLEN_W'(KEY_BYTES)) ?
                        KLEN_W'(KEY_BYTES) : req_key_length;
      for (int b = 0; b < KEY_W / 8; b++) begin
         req_key_masked[b*8 +: 8] = (KLEN_W'(b) < req_len_clamped) ?
                                    req_key_bytes[b*8 +: 8] : 8'd0;
      end
   end

   assign hash_byte = key_ff[byte_cnt_ff[2:0]*8 +: 8];

   lpht_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (TABLE_SIZE)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_slot),
      .rd_addr (idx_ff),
      .rd_data (rd_word)
   );

   assign rd_slot = slot_type'(rd_word);

   // A slot never written since reset reads as empty.
   assign probe_kind  = valid_ff[idx_ff] ? rd_slot.kind : KIND_EMPTY;
   assign key_match   = (rd_slot.key_length == len_ff) && (rd_slot.key == key_ff);
   assign value_match = (rd_slot.value == data_ff);
   assign last_probe  = (probe_cnt_ff == CNT_W'(TABLE_SIZE - 1));
   assign room_for_new = ({1'b0, used_ff} + (USED_W + 1)'(1)) <=
                         (USED_W + 1)'(limit_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               state_in = (func_type'(req_func) == FUNC_REVERSE) ? S_ISSUE : S_HASH;
            end
         end
         S_HASH: begin
            if (byte_cnt_ff == len_ff) begin
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (func_ff == FUNC_REVERSE) begin
               if ((probe_kind == KIND_USED && value_match) || last_probe) begin
                  state_in = S_DECIDE;
               end else begin
                  state_in = S_ISSUE;
               end
            end else if (probe_kind == KIND_EMPTY ||
                         (probe_kind == KIND_USED && key_match) || last_probe) begin
               state_in = S_DECIDE;
            end else begin
               state_in = S_ISSUE;
            end
         end
         S_DECIDE: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath and outputs of each state.
   always_comb begin
      req_stall     = (state_ff != S_IDLE);
      func_in       = func_ff;
      key_in        = key_ff;
      len_in        = len_ff;
      data_in       = data_ff;
      hash_in       = hash_ff;
      byte_cnt_in   = byte_cnt_ff;
      idx_in        = idx_ff;
      probe_cnt_in  = probe_cnt_ff;
      hit_in        = hit_ff;
      have_empty_in = have_empty_ff;
      have_tomb_in  = have_tomb_ff;
      hit_idx_in    = hit_idx_ff;
      empty_idx_in  = empty_idx_ff;
      tomb_idx_in   = tomb_idx_ff;
      hit_value_in  = hit_value_ff;
      hit_key_in    = hit_key_ff;
      hit_len_in    = hit_len_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_key_in    = res_key_ff;
      res_len_in    = res_len_ff;
      used_in       = used_ff;
      valid_in      = valid_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_slot       = '{kind: KIND_USED, key_length: len_ff, key: key_ff, value: data_ff};
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      out_found_in  = out_found_ff;
      out_status_in = out_status_ff;
      out_value_in  = out_value_ff;
      out_key_in    = out_key_ff;
      out_len_in    = out_len_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               func_in       = func_type'(req_func);
               key_in        = req_key_masked;
               len_in        = req_len_clamped;
               data_in       = req_data_value;
               hash_in       = FNV_OFFSET;
               byte_cnt_in   = '0;
               idx_in        = '0;
               probe_cnt_in  = '0;
               hit_in        = 1'b0;
               have_empty_in = 1'b0;
               have_tomb_in  = 1'b0;
            end
         end
         S_HASH: begin
            if (byte_cnt_ff == len_ff) begin
               idx_in = hash_ff[ADDR_W-1:0];
            end else begin
               hash_in     = (hash_ff ^ {24'd0, hash_byte}) * FNV_PRIME;
               byte_cnt_in = byte_cnt_ff + KLEN_W'(1);
            end
         end
         S_ISSUE: begin
            // The RAM read address is idx_ff; data returns in S_CHECK.
         end
         S_CHECK: begin
            if (func_ff == FUNC_REVERSE) begin
               if (probe_kind == KIND_USED && value_match) begin
                  hit_in     = 1'b1;
                  hit_key_in = rd_slot.key;
                  hit_len_in = rd_slot.key_length;
               end
            end else if (probe_kind == KIND_EMPTY) begin
               have_empty_in = 1'b1;
               empty_idx_in  = idx_ff;
            end else if (probe_kind == KIND_USED && key_match) begin
               hit_in       = 1'b1;
               hit_idx_in   = idx_ff;
               hit_value_in = rd_slot.value;
            end else if (probe_kind == KIND_TOMB && !have_tomb_ff) begin
               have_tomb_in = 1'b1;
               tomb_idx_in  = idx_ff;
            end
            idx_in       = idx_ff + ADDR_W'(1);
            probe_cnt_in = probe_cnt_ff + CNT_W'(1);
         end
         S_DECIDE: begin
            res_found_in  = 1'b0;
            res_status_in = STATUS_NOT_FOUND;
            res_value_in  = '0;
            res_key_in    = '0;
            res_len_in    = '0;
            case (func_ff)
               FUNC_LOOKUP: begin
                  if (hit_ff) begin
                     res_found_in  = 1'b1;
                     res_status_in = STATUS_OK;
                     res_value_in  = hit_value_ff;
                  end
               end
               FUNC_DELETE: begin
                  if (hit_ff) begin
                     wr_en         = 1'b1;
                     wr_addr       = hit_idx_ff;
                     wr_slot       = '{kind: KIND_TOMB, key_length: '0, key: '0,
                                       value: '0};
                     res_found_in  = 1'b1;
                     res_status_in = STATUS_OK;
                  end
               end
               FUNC_REVERSE: begin
                  if (hit_ff) begin
                     res_found_in  = 1'b1;
                     res_status_in = STATUS_OK;
                     res_key_in    = hit_key_ff;
                     res_len_in    = hit_len_ff;
                  end
               end
               default: begin
                  // Insert: overwrite, else reuse a tombstone, else a fresh slot.
                  res_status_in = STATUS_FULL;
                  if (hit_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = hit_idx_ff;
                  end else if (have_tomb_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = tomb_idx_ff;
                  end else if (have_empty_ff && room_for_new) begin
                     wr_en   = 1'b1;
                     wr_addr = empty_idx_ff;
                     used_in = used_ff + USED_W'(1);
                  end
                  if (wr_en) begin
                     res_found_in  = 1'b1;
                     res_status_in = STATUS_OK;
                  end
               end
            endcase
            if (wr_en) begin
               valid_in[wr_addr] = 1'b1;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_found_in  = res_found_ff;
               out_status_in = res_status_ff;
               out_value_in  = res_value_ff;
               out_key_in    = res_key_ff;
               out_len_in    = res_len_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         used_ff      <= '0;
         limit_ff     <= ENTRY_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      key_ff        <= key_in;
      len_ff        <= len_in;
      data_ff       <= data_in;
      hash_ff       <= hash_in;
      byte_cnt_ff   <= byte_cnt_in;
      idx_ff        <= idx_in;
      probe_cnt_ff  <= probe_cnt_in;
      hit_ff        <= hit_in;
      have_empty_ff <= have_empty_in;
      have_tomb_ff  <= have_tomb_in;
      hit_idx_ff    <= hit_idx_in;
      empty_idx_ff  <= empty_idx_in;
      tomb_idx_ff   <= tomb_idx_in;
      hit_value_ff  <= hit_value_in;
      hit_key_ff    <= hit_key_in;
      hit_len_ff    <= hit_len_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_key_ff    <= res_key_in;
      res_len_ff    <= res_len_in;
      out_found_ff  <= out_found_in;
      out_status_ff <= out_status_in;
      out_value_ff  <= out_value_in;
      out_key_ff    <= out_key_in;
      out_len_ff    <= out_len_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = out_found_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_value_out      = out_value_ff;
   assign rsp_key_out        = out_key_ff;
   assign rsp_key_out_length = out_len_ff;

   // The fill count only ever grows, and by one slot at a time.
   a_used_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (used_ff != $past(used_ff)) |->
         (used_ff == $past(used_ff) + USED_W'(1)))
      else $error("used slot count changed by other than one");

   // A slot write is always followed by the result hand-off.
   a_write_then_out: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (state_ff == S_OUT))
      else $error("slot write not followed by result stage");

   // A new response only appears after the result stage.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("response raised outside the result stage");

   // Found and an ok status always agree.
   a_found_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (out_found_ff == (out_status_ff == STATUS_OK)))
      else $error("found flag disagrees with status");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the linear probing hash table.
module tb_top;
   import lpht_pkg::*;

   // Clock and reset.
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #4 clock = ~clock;

   // Request channel. Every input starts at a known value.
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_func = FUNC_LOOKUP;
   logic [KEY_W-1:0]    req_key_bytes = '0;
   logic [KLEN_W-1:0]   req_key_length = '0;
   logic [VALUE_W-1:0]  req_data_value = '0;

   // Response channel.
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_found;
   logic [1:0]          rsp_status;
   logic [VALUE_W-1:0]  rsp_value_out;
   logic [KEY_W-1:0]    rsp_key_out;
   logic [KLEN_W-1:0]   rsp_key_out_length;

   // Entry limit register port.
   logic                csr_write_enable = 1'b0;
   logic [LIMIT_W-1:0]  csr_write_data = '0;

   linear_probe_hash_table dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_key_bytes      (req_key_bytes),
      .req_key_length     (req_key_length),
      .req_data_value     (req_data_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found          (rsp_found),
      .rsp_status         (rsp_status),
      .rsp_value_out      (rsp_value_out),
      .rsp_key_out        (rsp_key_out),
      .rsp_key_out_length (rsp_key_out_length),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   // One response beat as the table should produce it.
   typedef struct packed {
      logic                found;
      logic [1:0]          status;
      logic [VALUE_W-1:0]  value_out;
      logic [KEY_W-1:0]    key_out;
      logic [KLEN_W-1:0]   key_out_length;
   } answer_type;

   // One row of the directed table. When has_answer is set the typed-in
   // answer is checked against the predictor so the two agree by design.
   typedef struct {
      func_type            func;
      logic [KEY_W-1:0]    key;
      logic [KLEN_W-1:0]   len;
      logic [VALUE_W-1:0]  value;
      bit                  has_answer;
      answer_type          answer;
   } row_type;

   // Private copy of the table, kept in step with every accepted request.
   kind_type            shadow_kind [TABLE_SIZE];
   logic [KEY_W-1:0]    shadow_key  [TABLE_SIZE];
   logic [KLEN_W-1:0]   shadow_len  [TABLE_SIZE];
   logic [VALUE_W-1:0]  shadow_value[TABLE_SIZE];
   int unsigned         shadow_used;
   int unsigned         shadow_limit;

   answer_type pending_answers[$];
   int         error_count;
   int         accepted_requests;
   int         checked_answers;
   int         full_answers;
   int         reverse_hits;
   bit         quiet_mode;     // No idling on either side in the last part.
   bit         hold_response;  // Long receiver hold-off to fill the block.
   int         stall_left = 0; // Cycles still to go in a receiver stall burst.

   // Keys that the random part draws from, so that requests collide often.
   logic [KEY_W-1:0]   key_pool[16];
   logic [KLEN_W-1:0]  len_pool[16];
   logic [VALUE_W-1:0] value_pool[8];

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   function automatic logic [31:0] fnv_hash(input logic [KEY_W-1:0] key,
                                            input int unsigned len);
      logic [31:0] h;
      h = FNV_OFFSET;
      for (int i = 0; i < len; i++) begin
         h = (h ^ {24'd0, key[8*i +: 8]}) * FNV_PRIME;
      end
      return h;
   endfunction

   // Predicts the response of one request and updates the private table.
   function automatic answer_type table_step(input logic [1:0] func,
                                             input logic [KEY_W-1:0] raw_key,
                                             input logic [KLEN_W-1:0] raw_len,
                                             input logic [VALUE_W-1:0] value);
      answer_type  a;
      int unsigned len, idx, hit_idx, empty_idx, tomb_idx, dst;
      logic [KEY_W-1:0] key;
      bit hit, have_empty, have_tomb, place;
      a = '{1'b0, STATUS_NOT_FOUND, '0, '0, '0};
      // Long lengths saturate, and bytes past the length never count.
      len = (raw_len > KEY_BYTES) ? KEY_BYTES : raw_len;
      key = (len >= 8) ? raw_key : raw_key & ((64'd1 << (8 * len)) - 64'd1);
      hit = 0; have_empty = 0; have_tomb = 0; place = 0;
      hit_idx = 0; empty_idx = 0; tomb_idx = 0; dst = 0;
      if (func == FUNC_REVERSE) begin
         // The lowest numbered occupied slot with the value wins.
         for (int i = 0; i < TABLE_SIZE; i++) begin
            if (shadow_kind[i] == KIND_USED && shadow_value[i] == value) begin
               a = '{1'b1, STATUS_OK, '0, shadow_key[i], shadow_len[i]};
               break;
            end
         end
      end else begin
         idx = fnv_hash(key, len) % TABLE_SIZE;
         for (int n = 0; n < TABLE_SIZE; n++) begin
            if (shadow_kind[idx] == KIND_EMPTY) begin
               have_empty = 1;
               empty_idx = idx;
               break;
            end
            if (shadow_kind[idx] == KIND_TOMB) begin
               if (!have_tomb) begin
                  have_tomb = 1;
                  tomb_idx = idx;
               end
            end else if (shadow_len[idx] == len && shadow_key[idx] == key) begin
               hit = 1;
               hit_idx = idx;
               break;
            end
            idx = (idx + 1) % TABLE_SIZE;
         end
         case (func)
            FUNC_LOOKUP: begin
               if (hit) a = '{1'b1, STATUS_OK, shadow_value[hit_idx], '0, '0};
            end
            FUNC_DELETE: begin
               if (hit) begin
                  shadow_kind[hit_idx] = KIND_TOMB;
                  shadow_key[hit_idx] = '0;
                  shadow_len[hit_idx] = '0;
                  shadow_value[hit_idx] = '0;
                  a = '{1'b1, STATUS_OK, '0, '0, '0};
               end
            end
            default: begin
               // Overwrite first, then the first tombstone, then a fresh slot
               // while the entry limit allows one.
               if (hit) begin
                  place = 1; dst = hit_idx;
               end else if (have_tomb) begin
                  place = 1; dst = tomb_idx;
               end else if (have_empty && shadow_used + 1 <= shadow_limit) begin
                  place = 1; dst = empty_idx;
                  shadow_used++;
               end
               if (place) begin
                  shadow_kind[dst] = KIND_USED;
                  shadow_key[dst] = key;
                  shadow_len[dst] = len[KLEN_W-1:0];
                  shadow_value[dst] = value;
                  a = '{1'b1, STATUS_OK, '0, '0, '0};
               end else begin
                  a.status = STATUS_FULL;
               end
            end
         endcase
      end
      return a;
   endfunction

   // Drives one request beat at the falling edge and holds it until the
   // rising edge that accepts it. The answer is queued at acceptance.
   task automatic send_request(input logic [1:0] func, input logic [KEY_W-1:0] key,
                               input logic [KLEN_W-1:0] len,
                               input logic [VALUE_W-1:0] value);
      req_func <= func;
      req_key_bytes <= key;
      req_key_length <= len;
      req_data_value <= value;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      pending_answers.push_back(table_step(func, key, len, value));
      accepted_requests++;
      @(negedge clock);
      // Random gaps between beats, none in the quiet part.
      if (!quiet_mode && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
      // A reverse scan may visit every slot before its response.
      repeat (2 * TABLE_SIZE + 10) @(negedge clock);
   endtask

   // Registers are only written with nothing in flight.
   task automatic write_limit(input int unsigned limit);
      drain_and_settle();
      csr_write_data <= limit[LIMIT_W-1:0];
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      shadow_limit = limit;
   endtask

   task automatic send_random(input int count);
      int unsigned pick, func_pick;
      logic [KEY_W-1:0] key;
      logic [KLEN_W-1:0] len;
      logic [VALUE_W-1:0] value;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 15);
         key = key_pool[pick];
         len = len_pool[pick];
         // Mostly keys from the pool with noise in the bytes past the length.
         if ($urandom_range(0, 4) == 0) begin
            key = {$urandom, $urandom};
            len = KLEN_W'($urandom_range(0, 15));
         end else if (len < 8) begin
            key = key | ({$urandom, $urandom} << (8 * len));
         end
         value = ($urandom_range(0, 1) == 0) ? value_pool[$urandom_range(0, 7)]
                                             : $urandom;
         func_pick = $urandom_range(0, 9);
         if (func_pick < 4) send_request(FUNC_INSERT, key, len, value);
         else if (func_pick < 6) send_request(FUNC_LOOKUP, key, len, value);
         else if (func_pick < 8) send_request(FUNC_DELETE, key, len, value);
         else send_request(FUNC_REVERSE, key, len, value);
      end
   endtask

   // The receiver stalls in random bursts, or for one long stretch when
   // asked, and checks every accepted response against the oldest answer.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (hold_response) begin
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("unexpected response beat", 64'd1, 64'd0);
         end else begin
            want = pending_answers.pop_front();
            checked_answers++;
            if (want.status == STATUS_FULL) full_answers++;
            if (want.found && want.key_out_length != 0) reverse_hits++;
            if (rsp_found !== want.found)
               report_mismatch("found", 64'(rsp_found), 64'(want.found));
            if (rsp_status !== want.status)
               report_mismatch("status", 64'(rsp_status), 64'(want.status));
            if (rsp_value_out !== want.value_out)
               report_mismatch("value_out", 64'(rsp_value_out), 64'(want.value_out));
            if (rsp_key_out !== want.key_out)
               report_mismatch("key_out", rsp_key_out, want.key_out);
            if (rsp_key_out_length !== want.key_out_length)
               report_mismatch("key_out_length", 64'(rsp_key_out_length),
                               64'(want.key_out_length));
         end
      end
   end

   // The random burst stall above cannot last long, so the hold-off for
   // the pressure test is a counted stretch in its own process.
   task automatic hold_off_responses(input int cycles);
      hold_response = 1'b1;
      repeat (cycles) @(negedge clock);
      hold_response = 1'b0;
   endtask

   // Directed table: reset behavior, extreme fields, every function and
   // each special case. Answers that are obvious are typed in.
   row_type directed[] = '{
      '{FUNC_LOOKUP,  64'h0, 4'd0, 32'h0, 1, '{1'b0, STATUS_NOT_FOUND, 0, 0, 0}},
      '{FUNC_DELETE,  64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0, 1,
        '{1'b0, STATUS_NOT_FOUND, 0, 0, 0}},
      '{FUNC_REVERSE, 64'h0, 4'd0, 32'hFFFF_FFFF, 1,
        '{1'b0, STATUS_NOT_FOUND, 0, 0, 0}},
      '{FUNC_INSERT,  64'h0, 4'd0, 32'hFFFF_FFFF, 1, '{1'b1, STATUS_OK, 0, 0, 0}},
      '{FUNC_LOOKUP,  64'h0, 4'd0, 32'h0, 1,
        '{1'b1, STATUS_OK, 32'hFFFF_FFFF, 0, 0}},
      '{FUNC_INSERT,  64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0, 1,
        '{1'b1, STATUS_OK, 0, 0, 0}},
      // Long key length is taken as eight bytes.
      '{FUNC_LOOKUP,  64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'h0, 1,
        '{1'b1, STATUS_OK, 32'h0, 0, 0}},
      '{FUNC_REVERSE, 64'h0, 4'd0, 32'h0, 1,
        '{1'b1, STATUS_OK, 0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8}},
      // Stray bits past the length do not change the key.
      '{FUNC_INSERT,  64'h0000_0000_0000_0061, 4'd1, 32'h1234_5678, 1,
        '{1'b1, STATUS_OK, 0, 0, 0}},
      '{FUNC_LOOKUP,  64'hA5A5_A5A5_A5A5_A561, 4'd1, 32'h0, 1,
        '{1'b1, STATUS_OK, 32'h1234_5678, 0, 0}},
      '{FUNC_REVERSE, 64'h0, 4'd0, 32'h1234_5678, 1,
        '{1'b1, STATUS_OK, 0, 64'h61, 4'd1}},
      // Overwrite, then delete leaving a tombstone, then reuse it.
      '{FUNC_INSERT,  64'h61, 4'd1, 32'hCAFE_0001, 0, '{0, 0, 0, 0, 0}},
      '{FUNC_DELETE,  64'h61, 4'd1, 32'h0, 1, '{1'b1, STATUS_OK, 0, 0, 0}},
      '{FUNC_LOOKUP,  64'h61, 4'd1, 32'h0, 1, '{1'b0, STATUS_NOT_FOUND, 0, 0, 0}},
      '{FUNC_DELETE,  64'h61, 4'd1, 32'h0, 1, '{1'b0, STATUS_NOT_FOUND, 0, 0, 0}},
      '{FUNC_INSERT,  64'h6261, 4'd2, 32'h5555_AAAA, 0, '{0, 0, 0, 0, 0}},
      '{FUNC_INSERT,  64'h61, 4'd1, 32'hAAAA_5555, 0, '{0, 0, 0, 0, 0}},
      '{FUNC_INSERT,  64'h0123_4567_89AB_CDEF, 4'd7, 32'h8000_0000, 0,
        '{0, 0, 0, 0, 0}},
      '{FUNC_LOOKUP,  64'h0023_4567_89AB_CDEF, 4'd7, 32'h0, 0, '{0, 0, 0, 0, 0}},
      '{FUNC_REVERSE, 64'h0, 4'd0, 32'h8000_0000, 0, '{0, 0, 0, 0, 0}}
   };

   initial begin
      answer_type want;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         shadow_kind[i] = KIND_EMPTY;
         shadow_key[i] = '0;
         shadow_len[i] = '0;
         shadow_value[i] = '0;
      end
      shadow_used = 0;
      shadow_limit = ENTRY_LIMIT_RESET;
      error_count = 0;
      accepted_requests = 0;
      checked_answers = 0;
      full_answers = 0;
      reverse_hits = 0;
      quiet_mode = 1'b0;
      hold_response = 1'b0;
      for (int i = 0; i < 16; i++) begin
         len_pool[i] = KLEN_W'($urandom_range(0, 8));
         key_pool[i] = {$urandom, $urandom};
         if (len_pool[i] < 8)
            key_pool[i] = key_pool[i] & ((64'd1 << (8 * len_pool[i])) - 64'd1);
      end
      for (int i = 0; i < 8; i++) value_pool[i] = $urandom;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset limit.
      foreach (directed[i]) begin
         if (directed[i].has_answer) begin
            want = table_step_peek(directed[i]);
            if (want != directed[i].answer)
               report_mismatch("directed table row", 64'(i), 64'hFFFF);
         end
         send_request(directed[i].func, directed[i].key, directed[i].len,
                      directed[i].value);
      end

      // A limit of zero refuses every insert that needs a fresh slot, while
      // overwrites still succeed.
      write_limit(0);
      send_request(FUNC_INSERT, 64'h7A7A, 4'd2, 32'h1);
      send_request(FUNC_INSERT, 64'h61, 4'd1, 32'h2);

      // Random phases at the smallest, the largest and in-between limits.
      write_limit(1);
      send_random(40);
      write_limit(64);
      fork
         send_random(60);
         hold_off_responses(400);
      join
      write_limit(127);
      send_random(100);
      write_limit($urandom_range(2, 63));
      send_random(100);
      write_limit(ENTRY_LIMIT_RESET);
      quiet_mode = 1'b1;
      send_random(100);

      drain_and_settle();
      $display("ran %0d requests and checked %0d responses", accepted_requests,
               checked_answers);
      $display("saw %0d table-full refusals and %0d reverse lookup hits",
               full_answers, reverse_hits);
      if (error_count == 0) begin
         $display("linear_probe_hash_table regression: pass");
      end else begin
         $display("linear_probe_hash_table regression: fail");
      end
      $finish;
   end

   // Predicts a directed row without touching the private table.
   function automatic answer_type table_step_peek(input row_type row);
      kind_type          k[TABLE_SIZE];
      logic [KEY_W-1:0]  kk[TABLE_SIZE];
      logic [KLEN_W-1:0] kl[TABLE_SIZE];
      logic [VALUE_W-1:0] kv[TABLE_SIZE];
      int unsigned       u;
      answer_type        a;
      k = shadow_kind; kk = shadow_key; kl = shadow_len; kv = shadow_value;
      u = shadow_used;
      a = table_step(row.func, row.key, row.len, row.value);
      shadow_kind = k; shadow_key = kk; shadow_len = kl; shadow_value = kv;
      shadow_used = u;
      return a;
   endfunction

   // Watchdog for a hung block.
   initial begin
      #4000000;
      $display("linear_probe_hash_table regression: fail");
      $finish;
   end

endmodule
